[design/rmrd_pkg.sv]
`timescale 1ns / 1ps
package rmrd_pkg;

   localparam int DEF_REF_DEPTH      = 65536;
   localparam int DEF_MAX_READ       = 256;
   localparam int DEF_CHARS_PER_WORD = 8;

   localparam logic [17:0] CURSOR_MAX = 18'h3FFFF;
   localparam logic [15:0] ACCUM_MAX  = 16'hFFFF;

   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_T  = 8'h54;
   localparam logic [7:0] CH_UP_C  = 8'h43;
   localparam logic [7:0] CH_UP_G  = 8'h47;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_T  = 8'h74;
   localparam logic [7:0] CH_LO_C  = 8'h63;
   localparam logic [7:0] CH_LO_G  = 8'h67;
   localparam logic [7:0] CH_N     = 8'h4E;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_BEGIN = 2'd1,
      KIND_CHAR  = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_OVH_NUM,
      PH_OVH_SKIP,
      PH_OVH_COPY,
      PH_BODY,
      PH_MATCH
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH_RD,
      ST_MATCH_WR,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] ref_addr;
      logic [7:0]  ref_char;
      logic [15:0] start_pos;
      logic        orient_forward;
      logic        raw_mode;
      logic [7:0]  enc_char;
   } req_type;

   typedef struct packed {
      logic [63:0] out_chars;
      logic [3:0]  out_count;
      logic        out_last;
      logic        out_overflow;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] addr;
      logic [7:0]  ch;
      logic [15:0] start;
      logic        fwd;
      logic        raw;
   } cmd_type;

   function automatic logic [7:0] comp(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_UP_A: r = CH_UP_T;
         CH_UP_T: r = CH_UP_A;
         CH_UP_C: r = CH_UP_G;
         CH_UP_G: r = CH_UP_C;
         CH_LO_A: r = CH_LO_T;
         CH_LO_T: r = CH_LO_A;
         CH_LO_C: r = CH_LO_G;
         CH_LO_G: r = CH_LO_C;
         default: r = CH_N;
      endcase
      return r;
   endfunction

endpackage

[design/rmrd_front.sv]
`timescale 1ns / 1ps
module rmrd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rmrd_pkg::req_type req_data,
   input  logic             cmd_pop,
   output logic             cmd_empty,
   output rmrd_pkg::cmd_type cmd_data
);
   import rmrd_pkg::*;

   cmd_type    q_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   cmd_type    cls;

   // classify: keep only what the back end needs
   always_comb begin
      cls.kind  = kind_type'(req_data.req_type);
      cls.addr  = req_data.ref_addr;
      cls.ch    = (req_data.req_type == KIND_LOAD) ? req_data.ref_char : req_data.enc_char;
      cls.start = req_data.start_pos;
      cls.fwd   = req_data.orient_forward;
      cls.raw   = req_data.raw_mode;
   end

   assign req_full  = (cnt_ff == 3'd4);
   assign cmd_empty = (cnt_ff == 3'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && !cmd_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[design/rmrd_rsp_queue.sv]
`timescale 1ns / 1ps
module rmrd_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rmrd_pkg::rsp_type push_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output rmrd_pkg::rsp_type rsp_data
);
   import rmrd_pkg::*;

   rsp_type    q_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 3'd4);
   assign rsp_empty = (cnt_ff == 3'd0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/rmrd_back.sv]
`timescale 1ns / 1ps
module rmrd_back #(
   parameter int REF_DEPTH      = rmrd_pkg::DEF_REF_DEPTH,
   parameter int MAX_READ       = rmrd_pkg::DEF_MAX_READ,
   parameter int CHARS_PER_WORD = rmrd_pkg::DEF_CHARS_PER_WORD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  rmrd_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output rmrd_pkg::rsp_type rsp_word
);
   import rmrd_pkg::*;

   localparam int AW = $clog2(REF_DEPTH);
   localparam int BW = $clog2(MAX_READ);
   localparam int LW = $clog2(MAX_READ + 1);
   localparam logic [24:0]   REF_DEPTH_W = 25'(REF_DEPTH);
   localparam logic [LW-1:0] MAX_LEN     = LW'(MAX_READ);
   localparam logic [3:0]    CPW         = 4'(CHARS_PER_WORD);

   logic [7:0] ref_mem [REF_DEPTH];
   logic [7:0] buf_mem [MAX_READ];

   state_type     st_ff, st_in;
   phase_type     phase_ff, phase_in;
   logic [16:0]   ref_len_ff, ref_len_in;
   logic [LW-1:0] len_ff, len_in;
   logic [17:0]   cursor_ff, cursor_in;
   logic [15:0]   accum_ff, accum_in;
   logic          fwd_ff, fwd_in, raw_ff, raw_in, ovf_ff, ovf_in;
   logic [15:0]   k_ff, k_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [63:0]   word_ff, word_in;
   logic [7:0]    ref_rdata_ff, buf_rdata_ff;

   logic          ref_we, ref_re, buf_we, buf_re;
   logic [AW-1:0] ref_waddr, ref_raddr;
   logic [BW-1:0] buf_waddr, buf_raddr;
   logic [7:0]    ref_wdata, buf_wdata;

   logic [31:0]   addr_ext, p_ext;
   logic [18:0]   p;
   logic          load_ok, is_digit, buf_has_room, match_stop, rev;
   logic          need_match, emit_last, word_done;
   logic [LW-1:0] emit_idx;
   logic [7:0]    emit_ch, ch;
   logic [63:0]   word_new;

   function automatic logic [15:0] acc_next(input logic [15:0] a, input logic [7:0] c);
      logic [19:0] v;
      v = {1'b0, a, 3'b0} + {3'b0, a, 1'b0} + {12'd0, c - CH_ZERO};
      return (v > 20'(ACCUM_MAX)) ? ACCUM_MAX : v[15:0];
   endfunction

   function automatic logic [17:0] adv(input logic [17:0] cur, input logic [15:0] n);
      logic [18:0] v;
      v = {1'b0, cur} + {3'b0, n};
      return (v > 19'(CURSOR_MAX)) ? CURSOR_MAX : v[17:0];
   endfunction

   assign ch           = cmd_data.ch;
   assign addr_ext     = {16'd0, cmd_data.addr};
   assign load_ok      = {9'd0, cmd_data.addr} < REF_DEPTH_W;
   assign is_digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign buf_has_room = (len_ff != MAX_LEN);
   assign p            = {1'b0, cursor_ff} + {3'b0, k_ff};
   assign p_ext        = {13'd0, p};
   assign match_stop   = (k_ff == accum_ff) || ({6'd0, p} >= REF_DEPTH_W)
                         || (p >= {2'b0, ref_len_ff}) || !buf_has_room;
   assign rev          = !raw_ff && !fwd_ff;
   // a pending match is flushed before the char or end that closes it
   assign need_match   = !raw_ff && (phase_ff == PH_MATCH)
                         && ((cmd_data.kind == KIND_END)
                             || ((cmd_data.kind == KIND_CHAR) && !is_digit));
   assign emit_idx     = rev ? (len_ff - LW'(1) - idx_ff) : idx_ff;
   assign emit_last    = (idx_ff + LW'(1) == len_ff);
   assign emit_ch      = rev ? comp(buf_rdata_ff) : buf_rdata_ff;
   assign word_new     = word_ff | ({56'd0, emit_ch} << {cnt_ff, 3'b000});
   assign word_done    = (cnt_ff + 4'd1 == CPW) || emit_last;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (need_match) begin
                  st_in = ST_MATCH_RD;
               end else if (cmd_data.kind == KIND_END && len_ff != '0) begin
                  st_in = ST_EMIT_RD;
               end
            end
         end
         ST_MATCH_RD: st_in = match_stop ? ST_IDLE : ST_MATCH_WR;
         ST_MATCH_WR: st_in = ST_MATCH_RD;
         ST_EMIT_RD:  st_in = ST_EMIT_WR;
         ST_EMIT_WR: begin
            if (word_done && rsp_full) begin
               st_in = ST_EMIT_WR;
            end else if (emit_last) begin
               st_in = ST_IDLE;
            end else begin
               st_in = ST_EMIT_RD;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      phase_in   = phase_ff;
      ref_len_in = ref_len_ff;
      len_in     = len_ff;
      cursor_in  = cursor_ff;
      accum_in   = accum_ff;
      fwd_in     = fwd_ff;
      raw_in     = raw_ff;
      ovf_in     = ovf_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      word_in    = word_ff;
      cmd_pop    = 1'b0;
      ref_we     = 1'b0;
      ref_re     = 1'b0;
      buf_we     = 1'b0;
      buf_re     = 1'b0;
      ref_waddr  = addr_ext[AW-1:0];
      ref_wdata  = ch;
      ref_raddr  = p_ext[AW-1:0];
      buf_waddr  = len_ff[BW-1:0];
      buf_wdata  = ch;
      buf_raddr  = emit_idx[BW-1:0];
      rsp_push   = 1'b0;
      rsp_word.out_chars    = word_new;
      rsp_word.out_count    = cnt_ff + 4'd1;
      rsp_word.out_last     = emit_last;
      rsp_word.out_overflow = ovf_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (need_match) begin
                  k_in = '0;
               end else begin
                  case (cmd_data.kind)
                     KIND_LOAD: begin
                        cmd_pop = 1'b1;
                        if (load_ok) begin
                           ref_we     = 1'b1;
                           ref_len_in = {1'b0, cmd_data.addr} + 17'd1;
                        end
                     end
                     KIND_BEGIN: begin
                        cmd_pop   = 1'b1;
                        len_in    = '0;
                        cursor_in = {2'b0, cmd_data.start};
                        phase_in  = PH_FIRST;
                        accum_in  = '0;
                        fwd_in    = cmd_data.fwd;
                        raw_in    = cmd_data.raw;
                        ovf_in    = 1'b0;
                     end
                     KIND_CHAR: begin
                        cmd_pop = 1'b1;
                        if (raw_ff) begin
                           if (buf_has_room) begin
                              buf_we = 1'b1;
                              len_in = len_ff + LW'(1);
                           end else begin
                              ovf_in = 1'b1;
                           end
                        end else begin
                           case (phase_ff)
                              PH_OVH_NUM: begin
                                 if (is_digit) begin
                                    accum_in = acc_next(accum_ff, ch);
                                 end else if (ch == CH_COLON) begin
                                    phase_in = (accum_ff != '0) ? PH_OVH_COPY : PH_BODY;
                                 end else begin
                                    phase_in = PH_OVH_SKIP;
                                 end
                              end
                              PH_OVH_SKIP: begin
                                 if (ch == CH_COLON) begin
                                    phase_in = (accum_ff != '0) ? PH_OVH_COPY : PH_BODY;
                                 end
                              end
                              PH_OVH_COPY: begin
                                 if (buf_has_room) begin
                                    buf_we = 1'b1;
                                    len_in = len_ff + LW'(1);
                                 end else begin
                                    ovf_in = 1'b1;
                                 end
                                 accum_in = accum_ff - 16'd1;
                                 if (accum_ff == 16'd1) begin
                                    phase_in = PH_BODY;
                                 end
                              end
                              PH_MATCH: begin
                                 accum_in = acc_next(accum_ff, ch);
                              end
                              default: begin
                                 // first char or body
                                 if (phase_ff == PH_FIRST && ch == CH_DASH) begin
                                    phase_in = PH_OVH_NUM;
                                    accum_in = '0;
                                 end else if (ch == CH_M) begin
                                    phase_in = PH_MATCH;
                                    accum_in = '0;
                                 end else begin
                                    phase_in  = PH_BODY;
                                    cursor_in = adv(cursor_ff, 16'd1);
                                    if (buf_has_room) begin
                                       buf_we = 1'b1;
                                       len_in = len_ff + LW'(1);
                                    end else begin
                                       ovf_in = 1'b1;
                                    end
                                 end
                              end
                           endcase
                        end
                     end
                     KIND_END: begin
                        idx_in  = '0;
                        cnt_in  = '0;
                        word_in = '0;
                        if (len_ff == '0) begin
                           cmd_pop   = 1'b1;
                           cursor_in = '0;
                           phase_in  = PH_FIRST;
                           accum_in  = '0;
                           fwd_in    = 1'b1;
                           raw_in    = 1'b0;
                           ovf_in    = 1'b0;
                        end
                     end
                     default: cmd_pop = 1'b0;
                  endcase
               end
            end
         end
         ST_MATCH_RD: begin
            if (match_stop) begin
               // the closing char or end is then taken again from the queue head
               if (k_ff != accum_ff && {6'd0, p} < REF_DEPTH_W
                   && p < {2'b0, ref_len_ff} && !buf_has_room) begin
                  ovf_in = 1'b1;
               end
               cursor_in = adv(cursor_ff, accum_ff);
               accum_in  = '0;
               phase_in  = PH_BODY;
            end else begin
               ref_re = 1'b1;
            end
         end
         ST_MATCH_WR: begin
            buf_we    = 1'b1;
            buf_wdata = ref_rdata_ff;
            len_in    = len_ff + LW'(1);
            k_in      = k_ff + 16'd1;
         end
         ST_EMIT_RD: begin
            buf_re = 1'b1;
         end
         ST_EMIT_WR: begin
            if (!word_done) begin
               word_in = word_new;
               cnt_in  = cnt_ff + 4'd1;
               idx_in  = idx_ff + LW'(1);
            end else if (!rsp_full) begin
               rsp_push = 1'b1;
               word_in  = '0;
               cnt_in   = '0;
               idx_in   = idx_ff + LW'(1);
               if (emit_last) begin
                  cmd_pop   = 1'b1;
                  len_in    = '0;
                  cursor_in = '0;
                  phase_in  = PH_FIRST;
                  accum_in  = '0;
                  fwd_in    = 1'b1;
                  raw_in    = 1'b0;
                  ovf_in    = 1'b0;
               end
            end
         end
         default: cmd_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         phase_ff   <= PH_FIRST;
         ref_len_ff <= '0;
         len_ff     <= '0;
         cursor_ff  <= '0;
         accum_ff   <= '0;
         fwd_ff     <= 1'b1;
         raw_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         st_ff      <= st_in;
         phase_ff   <= phase_in;
         ref_len_ff <= ref_len_in;
         len_ff     <= len_in;
         cursor_ff  <= cursor_in;
         accum_ff   <= accum_in;
         fwd_ff     <= fwd_in;
         raw_ff     <= raw_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_waddr] <= ref_wdata;
      end
      if (ref_re) begin
         ref_rdata_ff <= ref_mem[ref_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      if (buf_re) begin
         buf_rdata_ff <= buf_mem[buf_raddr];
      end
   end

endmodule

[design/reference_match_run_decoder.sv]
`timescale 1ns / 1ps
// Channel | Ports                         | Beat taken when
// --------+-------------------------------+-------------------------
// request | req_push, req_full, req_data  | req_push && !req_full
// result  | rsp_empty, rsp_pop, rsp_data  | rsp_pop && !rsp_empty
//
// Load, begin and literal/prefix chars are handled in the idle state.
// A match copy reads each copied char on the single reference memory
// read port and writes it to the read buffer, before the char or end
// that closes it is taken. An end item reads and packs each char of the
// read, and stalls while the result queue is full.
// A 4-beat request queue and a 4-beat result queue decouple both sides.
// Reset is synchronous and clears control state; memories need no clearing.
module reference_match_run_decoder #(
   parameter int REF_DEPTH      = rmrd_pkg::DEF_REF_DEPTH,
   parameter int MAX_READ       = rmrd_pkg::DEF_MAX_READ,
   parameter int CHARS_PER_WORD = rmrd_pkg::DEF_CHARS_PER_WORD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rmrd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rmrd_pkg::rsp_type rsp_data
);
   import rmrd_pkg::*;

   cmd_type cmd_data;
   rsp_type push_word;
   logic    cmd_empty, cmd_pop, rsp_full, rsp_push;

   rmrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data)
   );

   rmrd_back #(
      .REF_DEPTH      (REF_DEPTH),
      .MAX_READ       (MAX_READ),
      .CHARS_PER_WORD (CHARS_PER_WORD)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_word  (push_word)
   );

   rmrd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .full      (rsp_full),
      .push_data (push_word),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

[design/rmrd_checker.sv]
`timescale 1ns / 1ps
module rmrd_checker #(
   parameter int CHARS_PER_WORD = rmrd_pkg::DEF_CHARS_PER_WORD
) (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input rmrd_pkg::rsp_type rsp_data
);
   import rmrd_pkg::*;

   localparam logic [3:0] CPW = 4'(CHARS_PER_WORD);

   // nothing is waiting right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_room_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full right after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.out_count != 4'd0 && rsp_data.out_count <= CPW))
      else $error("word count out of range");

   // only the final word of a read may be short
   a_full_words: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.out_last) |-> rsp_data.out_count == CPW)
      else $error("short word before the end of a read");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind reference_match_run_decoder rmrd_checker #(.CHARS_PER_WORD(CHARS_PER_WORD)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

[bench/tb_reference_match_run_decoder.sv]
`timescale 1ns / 1ps
module tb_reference_match_run_decoder;
   import rmrd_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   reference_match_run_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   typedef struct {
      req_type item;
      int      n_fixed;   // -1: take the predictor's words
      rsp_type word;
   } row_type;

   // predictor state
   logic [7:0]  ref_mem [65536];
   int unsigned ref_len;
   logic [7:0]  rbuf [256];
   int unsigned rlen;
   int unsigned cur;
   int unsigned acc;
   phase_type   ph;
   bit          fwd, raw, ovf;

   rsp_type words_due[$];
   int      errors;
   int      tx_idle, rx_idle;
   int      sent;
   int      ref_written;   // addresses 0..ref_written-1 hold known data

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [7:0] base_pair(input logic [7:0] c);
      case (c)
         CH_UP_A: return CH_UP_T;
         CH_UP_T: return CH_UP_A;
         CH_UP_C: return CH_UP_G;
         CH_UP_G: return CH_UP_C;
         CH_LO_A: return CH_LO_T;
         CH_LO_T: return CH_LO_A;
         CH_LO_C: return CH_LO_G;
         CH_LO_G: return CH_LO_C;
         default: return CH_N;
      endcase
   endfunction

   function automatic void read_clear();
      rlen = 0;
      cur  = 0;
      ph   = PH_FIRST;
      acc  = 0;
      fwd  = 1'b1;
      raw  = 1'b0;
      ovf  = 1'b0;
   endfunction

   function automatic void buf_put(input logic [7:0] c);
      if (rlen < 256) begin
         rbuf[rlen] = c;
         rlen++;
      end else begin
         ovf = 1'b1;
      end
   endfunction

   function automatic void cursor_add(input int unsigned n);
      cur = (cur + n > 262143) ? 262143 : cur + n;
   endfunction

   function automatic void acc_digit(input logic [7:0] c);
      int unsigned v;
      v = acc * 10 + (c - CH_ZERO);
      acc = v > 65535 ? 65535 : v;
   endfunction

   function automatic void copy_run();
      int unsigned p;
      for (int unsigned k = 0; k < acc; k++) begin
         p = cur + k;
         if (p >= ref_len || p >= 65536) break;
         if (rlen >= 256) begin
            ovf = 1'b1;
            break;
         end
         rbuf[rlen] = ref_mem[p];
         rlen++;
      end
      cursor_add(acc);
      acc = 0;
   endfunction

   function automatic void body_step(input logic [7:0] c);
      if (c == CH_M) begin
         ph  = PH_MATCH;
         acc = 0;
      end else begin
         buf_put(c);
         cursor_add(1);
      end
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void decode_step(input logic [7:0] c);
      case (ph)
         PH_FIRST: begin
            if (c == CH_DASH) begin
               ph  = PH_OVH_NUM;
               acc = 0;
            end else begin
               ph = PH_BODY;
               body_step(c);
            end
         end
         PH_OVH_NUM: begin
            if (is_digit(c)) acc_digit(c);
            else if (c == CH_COLON) ph = acc != 0 ? PH_OVH_COPY : PH_BODY;
            else ph = PH_OVH_SKIP;
         end
         PH_OVH_SKIP: begin
            if (c == CH_COLON) ph = acc != 0 ? PH_OVH_COPY : PH_BODY;
         end
         PH_OVH_COPY: begin
            buf_put(c);
            acc--;
            if (acc == 0) ph = PH_BODY;
         end
         PH_MATCH: begin
            if (is_digit(c)) begin
               acc_digit(c);
            end else begin
               copy_run();
               ph = PH_BODY;
               body_step(c);
            end
         end
         default: body_step(c);
      endcase
   endfunction

   function automatic void pack_words();
      bit          rev;
      int unsigned i;
      rsp_type     w;
      rev = !raw && !fwd;
      i = 0;
      while (i < rlen) begin
         w = '0;
         w.out_overflow = ovf;
         while (w.out_count < 8 && i < rlen) begin
            w.out_chars[8 * w.out_count +: 8] = rev ? base_pair(rbuf[rlen - 1 - i]) : rbuf[i];
            w.out_count++;
            i++;
         end
         w.out_last = i >= rlen;
         words_due.insert(words_due.size(), w);
      end
   endfunction

   function automatic void predict(input req_type x);
      case (kind_type'(x.req_type))
         KIND_LOAD: begin
            ref_mem[x.ref_addr] = x.ref_char;
            ref_len = x.ref_addr + 1;
         end
         KIND_BEGIN: begin
            read_clear();
            cur = {16'd0, x.start_pos};
            fwd = x.orient_forward;
            raw = x.raw_mode;
         end
         KIND_CHAR: begin
            if (raw) buf_put(x.enc_char);
            else decode_step(x.enc_char);
         end
         default: begin
            if (!raw && ph == PH_MATCH) copy_run();
            pack_words();
            read_clear();
         end
      endcase
   endfunction

   task automatic send(input req_type x, input int n_fixed, input rsp_type word);
      int n_prior;
      while ($urandom_range(99) < tx_idle) begin
         req_push = 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_push = 1'b1;
      req_data = x;
      do @(posedge clock); while (req_full);
      n_prior = words_due.size();
      predict(x);
      if (n_fixed >= 0) begin
         while (words_due.size() > n_prior) void'(words_due.pop_back());
         if (n_fixed > 0) words_due.insert(words_due.size(), word);
      end
      sent++;
      @(negedge clock);
   endtask

   function automatic req_type mk(input kind_type k, input logic [7:0] c);
      req_type     x;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      x = noise[$bits(req_type)-1:0];
      x.req_type = k;
      x.enc_char = c;
      return x;
   endfunction

   task automatic put(input req_type x);
      send(x, -1, '0);
   endtask

   task automatic put_load(input logic [15:0] a, input logic [7:0] c);
      req_type x;
      x = mk(KIND_LOAD, 8'h00);
      x.ref_addr = a;
      x.ref_char = c;
      put(x);
   endtask

   task automatic put_num(input int unsigned v);
      string s;
      s.itoa(v);
      for (int i = 0; i < s.len(); i++) put(mk(KIND_CHAR, s[i]));
   endtask

   function automatic logic [7:0] pick_base();
      logic [7:0] alpha[12];
      alpha = '{CH_UP_A, CH_UP_C, CH_UP_G, CH_UP_T, CH_LO_A, CH_LO_C, CH_LO_G, CH_LO_T,
                CH_N, 8'h78, CH_COLON, CH_DASH};
      return alpha[$urandom_range(11)];
   endfunction

   // one read with random content; mostly well formed
   task automatic random_read();
      req_type x;
      int      tokens;
      int      roll;
      if ($urandom_range(99) < 30) begin
         if (ref_written < 64) begin
            put_load(16'(ref_written), 8'($urandom_range(255)));
            ref_written++;
         end else begin
            put_load(16'($urandom_range(ref_written - 1)), 8'($urandom_range(255)));
         end
      end
      if ($urandom_range(99) < 3) begin
         // far load stretches the length; pull it back before any copy
         put_load(16'($urandom_range(65535)), 8'($urandom_range(255)));
         put_load(16'(ref_written - 1), 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 95) begin
         x = mk(KIND_BEGIN, 8'h00);
         x.start_pos = ($urandom_range(99) < 80) ? 16'($urandom_range(40))
                                                 : 16'($urandom_range(65535));
         x.orient_forward = 1'($urandom_range(1));
         x.raw_mode = $urandom_range(99) < 8;
         put(x);
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
         tokens = $urandom_range(1, 10);
         repeat (tokens) put(mk(KIND_CHAR, 8'($urandom_range(255))));
      end else if (roll < 12) begin
         repeat ($urandom_range(257, 280)) put(mk(KIND_CHAR, pick_base()));
      end else begin
         if ($urandom_range(99) < 30) begin
            put(mk(KIND_CHAR, CH_DASH));
            put_num($urandom_range(5));
            if ($urandom_range(99) < 15) put(mk(KIND_CHAR, 8'h78));
            if ($urandom_range(99) < 95) put(mk(KIND_CHAR, CH_COLON));
         end
         tokens = $urandom_range(1, 10);
         repeat (tokens) begin
            if ($urandom_range(99) < 30) begin
               put(mk(KIND_CHAR, CH_M));
               case ($urandom_range(9))
                  0: ;
                  1: put_num(65535 + $urandom_range(9) * 10);
                  default: put_num($urandom_range(20));
               endcase
            end else begin
               put(mk(KIND_CHAR, pick_base()));
            end
         end
      end
      if ($urandom_range(99) < 95) put(mk(KIND_END, 8'h00));
   endtask

   // result side
   initial begin
      rsp_type w;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (words_due.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_data);
               errors++;
            end else begin
               w = words_due.pop_front();
               if (rsp_data.out_chars !== w.out_chars) begin
                  $display("%0t: out_chars exp %h got %h", $time, w.out_chars,
                           rsp_data.out_chars);
                  errors++;
               end
               if (rsp_data.out_count !== w.out_count) begin
                  $display("%0t: out_count exp %0d got %0d", $time, w.out_count,
                           rsp_data.out_count);
                  errors++;
               end
               if (rsp_data.out_last !== w.out_last) begin
                  $display("%0t: out_last exp %b got %b", $time, w.out_last,
                           rsp_data.out_last);
                  errors++;
               end
               if (rsp_data.out_overflow !== w.out_overflow) begin
                  $display("%0t: out_overflow exp %b got %b", $time, w.out_overflow,
                           rsp_data.out_overflow);
                  errors++;
               end
            end
         end
         @(negedge clock);
         rsp_pop = $urandom_range(99) >= rx_idle;
      end
   end

   initial begin
      row_type rows[$];
      row_type r;
      int      wait_cycles;
      errors = 0;
      sent = 0;
      tx_idle = 0;
      rx_idle = 0;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      ref_len = 0;
      read_clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty end, loads, lone char, copies, prefix, raw, extremes
      r = '{mk(KIND_END, 8'h00), 0, '0};                   rows.insert(rows.size(), r);
      r = '{mk(KIND_LOAD, 8'h00), -1, '0}; r.item.ref_addr = 0; r.item.ref_char = CH_UP_A;
      rows.insert(rows.size(), r);
      r.item.ref_addr = 1; r.item.ref_char = CH_UP_C;      rows.insert(rows.size(), r);
      r.item.ref_addr = 2; r.item.ref_char = CH_UP_G;      rows.insert(rows.size(), r);
      r.item.ref_addr = 3; r.item.ref_char = CH_UP_T;      rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_UP_G), -1, '0};               rows.insert(rows.size(), r);
      r = '{mk(KIND_END, 8'h00), 1, '{64'h47, 4'd1, 1'b1, 1'b0}};
      rows.insert(rows.size(), r);
      r = '{mk(KIND_BEGIN, 8'h00), -1, '0};
      r.item.start_pos = 0; r.item.orient_forward = 1; r.item.raw_mode = 0;
      rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_M), -1, '0};                  rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, 8'h34), -1, '0};                 rows.insert(rows.size(), r);
      r = '{mk(KIND_END, 8'h00), 1, '{64'h54474341, 4'd4, 1'b1, 1'b0}};
      rows.insert(rows.size(), r);
      r = '{mk(KIND_BEGIN, 8'h00), -1, '0};
      r.item.start_pos = 1; r.item.orient_forward = 0; r.item.raw_mode = 0;
      rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_DASH), -1, '0};               rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, 8'h31), -1, '0};                 rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_COLON), -1, '0};              rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, 8'h7A), -1, '0};                 rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_M), -1, '0};                  rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_NINE), -1, '0};               rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_M), -1, '0};                  rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, CH_COLON), -1, '0};              rows.insert(rows.size(), r);
      r = '{mk(KIND_END, 8'h00), -1, '0};                  rows.insert(rows.size(), r);
      r = '{mk(KIND_BEGIN, 8'h00), -1, '0};
      r.item.start_pos = 16'hFFFF; r.item.orient_forward = 0; r.item.raw_mode = 1;
      rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, 8'hFF), -1, '0};                 rows.insert(rows.size(), r);
      r = '{mk(KIND_CHAR, 8'h00), -1, '0};                 rows.insert(rows.size(), r);
      r = '{mk(KIND_END, 8'h00), 1, '{64'h00FF, 4'd2, 1'b1, 1'b0}};
      rows.insert(rows.size(), r);
      r = '{mk(KIND_LOAD, 8'h00), -1, '0}; r.item.ref_addr = 16'hFFFF; r.item.ref_char = 8'hFF;
      rows.insert(rows.size(), r);
      r.item.ref_addr = 3; r.item.ref_char = CH_UP_T;      rows.insert(rows.size(), r);
      foreach (rows[i]) send(rows[i].item, rows[i].n_fixed, rows[i].word);
      ref_written = 4;

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle = phase == 0 ? 9 : (phase == 1 ? 50 : 0);
         rx_idle = phase == 0 ? 50 : (phase == 1 ? 9 : 0);
         while (sent < 30 + 135 * (phase + 1)) random_read();
         if (phase == 0) begin
            // hold the sender until the result side has drained
            req_push = 1'b0;
            while (words_due.size() != 0) @(negedge clock);
         end
      end
      req_push = 1'b0;

      wait_cycles = 0;
      while (words_due.size() != 0 && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (1200) @(negedge clock);
      if (errors == 0 && words_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         if (words_due.size() != 0)
            $display("%0t: %0d expected beats never came", $time, words_due.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
design/rmrd_pkg.sv
design/rmrd_front.sv
design/rmrd_rsp_queue.sv
design/rmrd_back.sv
design/reference_match_run_decoder.sv
design/rmrd_checker.sv
bench/tb_reference_match_run_decoder.sv
